[src/canrx_pkg.sv]
// canrx_pkg: shared types and constants for the can receive mailbox router
// no dependencies; used by the top level and its checker

package canrx_pkg;

   // default sizing, handed to the top level parameters
   localparam int NUM_MAILBOXES_DEF = 4;
   localparam int QUEUE_DEPTH_DEF   = 8;

   // filter register file
   localparam int NUM_REGS    = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int FILTER_W    = 31;

   // filter register layout
   localparam int FLT_ATTACH_BIT = 30;
   localparam int FLT_EXT_BIT    = 29;
   localparam int STD_ID_W       = 11;

   // payload widths
   localparam int ID_W       = 29;
   localparam int DLC_W      = 4;
   localparam int DATA_W     = 64;
   localparam int INDEX_W    = 2;
   localparam int MASK_W     = 4;
   localparam int REMAIN_W   = 4;
   localparam int OVF_W      = 16;
   localparam logic [OVF_W-1:0] OVF_MAX = '1;

   // item modes
   localparam logic MODE_ROUTE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WRITE,
      ST_RDATA
   } canrx_state_type;

endpackage

[src/can_rx_mailbox_router.sv]
// can_rx_mailbox_router: id filters, per-mailbox fifo control and a shared message memory
// depends on canrx_pkg
//
// Usage
// - req channel (valid/stall): one beat is either a received frame to route (mode 0)
//   or a pop of one mailbox (mode 1). rsp channel (valid/stall): exactly one beat per
//   request. csr channel (valid/ready, always ready): writes mailbox filters 0..3; the
//   user must write them only while the block is idle; the block does not enforce this.
// - a routed frame is compared against all attached filters in the accept cycle; the
//   response (matched and dropped masks) is registered at that edge, so it shows in
//   the next cycle. The frame is then written into the shared message memory, one
//   matching mailbox per cycle, until every stored copy is written.
// - a pop reads the message memory at the mailbox head into the registered read port;
//   the response is loaded from that port in the read-data state.
// - one request is in flight at a time; the request channel stalls until the write sweep
//   through the single memory write port or the registered read is done.
// - the response sits in an output register; a stalled response holds and blocks
//   the next request from completing, nothing is lost.
// - reset clears filters, fifo pointers, fill levels and drop counters at once;
//   the message memory needs no clearing, since only written entries are popped.

module can_rx_mailbox_router #(
   parameter int NUM_MAILBOXES = canrx_pkg::NUM_MAILBOXES_DEF,
   parameter int QUEUE_DEPTH   = canrx_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_mode,
   input  logic                                req_frame_ide,
   input  logic [canrx_pkg::ID_W-1:0]          req_frame_id,
   input  logic [canrx_pkg::DLC_W-1:0]         req_frame_dlc,
   input  logic [canrx_pkg::DATA_W-1:0]        req_frame_data,
   input  logic [canrx_pkg::INDEX_W-1:0]       req_read_index,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [canrx_pkg::MASK_W-1:0]        rsp_matched_mask,
   output logic [canrx_pkg::MASK_W-1:0]        rsp_dropped_mask,
   output logic                                rsp_read_valid,
   output logic                                rsp_read_ide,
   output logic [canrx_pkg::ID_W-1:0]          rsp_read_id,
   output logic [canrx_pkg::DLC_W-1:0]         rsp_read_dlc,
   output logic [canrx_pkg::DATA_W-1:0]        rsp_read_data,
   output logic [canrx_pkg::REMAIN_W-1:0]      rsp_remaining,
   output logic [canrx_pkg::OVF_W-1:0]         rsp_overflow_count,
   // filter register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [canrx_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [canrx_pkg::FILTER_W-1:0]      csr_wdata
);

   localparam int MB_W      = (NUM_MAILBOXES > 1) ? $clog2(NUM_MAILBOXES) : 1;
   localparam int SLOT_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W     = FILL_W + 1;
   localparam int MEM_DEPTH = NUM_MAILBOXES * QUEUE_DEPTH;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int ENTRY_W   = canrx_pkg::DLC_W + canrx_pkg::DATA_W;

   // control and configuration state
   canrx_pkg::canrx_state_type state_ff, state_in;
   logic [NUM_MAILBOXES-1:0]       pend_ff, pend_in;
   logic [canrx_pkg::FILTER_W-1:0] filter_ff [canrx_pkg::NUM_REGS];
   logic [SLOT_W-1:0]              head_ff   [NUM_MAILBOXES];
   logic [FILL_W-1:0]              fill_ff   [NUM_MAILBOXES];
   logic [canrx_pkg::OVF_W-1:0]    drop_ff   [NUM_MAILBOXES];

   // message memory and its registered read port
   logic [ENTRY_W-1:0] msg_mem [MEM_DEPTH];
   logic [ENTRY_W-1:0] mem_q_ff;

   // captured frame payload for the write sweep
   logic [canrx_pkg::DLC_W-1:0]  dlc_ff;
   logic [canrx_pkg::DATA_W-1:0] data_ff;

   // response register
   logic                          rsp_valid_ff;
   logic [canrx_pkg::MASK_W-1:0]  rsp_matched_ff;
   logic [canrx_pkg::MASK_W-1:0]  rsp_dropped_ff;
   logic                          rsp_read_valid_ff;
   logic                          rsp_read_ide_ff;
   logic [canrx_pkg::ID_W-1:0]    rsp_read_id_ff;
   logic [canrx_pkg::DLC_W-1:0]   rsp_read_dlc_ff;
   logic [canrx_pkg::DATA_W-1:0]  rsp_read_data_ff;
   logic [canrx_pkg::REMAIN_W-1:0] rsp_remaining_ff;
   logic [canrx_pkg::OVF_W-1:0]   rsp_overflow_ff;

   // combinational controls
   logic                     out_free;
   logic                     req_take;
   logic                     take_route;
   logic                     take_read;
   logic [NUM_MAILBOXES-1:0] match_vec;
   logic [NUM_MAILBOXES-1:0] full_vec;
   logic [NUM_MAILBOXES-1:0] acc_vec;
   logic [NUM_MAILBOXES-1:0] drop_vec;
   logic                     rd_ok;
   logic [MB_W-1:0]          rd_mb;
   logic                     rd_hit;
   logic [FILL_W-1:0]        rd_fill_left;
   logic [SLOT_W-1:0]        rd_head_next;
   logic [ADDR_W-1:0]        rd_addr;
   logic [canrx_pkg::FILTER_W-1:0] rd_filter;
   logic [NUM_MAILBOXES-1:0] wr_sel;
   logic [MB_W-1:0]          wr_mb;
   logic [SUM_W-1:0]         wr_sum;
   logic [SLOT_W-1:0]        wr_slot;
   logic [ADDR_W-1:0]        wr_addr;
   logic                     wr_en;
   logic                     rdata_load;

   // handshakes
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != canrx_pkg::ST_IDLE) || !out_free;
   assign req_take   = req_valid && !req_stall;
   assign take_route = req_take && (req_mode == canrx_pkg::MODE_ROUTE);
   assign take_read  = req_take && (req_mode == canrx_pkg::MODE_READ);
   assign csr_ready  = 1'b1;

   // filter compare against every mailbox
   always_comb begin
      logic [canrx_pkg::FILTER_W-1:0] flt;
      logic                           id_eq;
      for (int m = 0; m < NUM_MAILBOXES; m++) begin
         flt = filter_ff[m];
         if (req_frame_ide) begin
            id_eq = (flt[canrx_pkg::ID_W-1:0] == req_frame_id);
         end else begin
            id_eq = (flt[canrx_pkg::STD_ID_W-1:0] == req_frame_id[canrx_pkg::STD_ID_W-1:0]);
         end
         match_vec[m] = flt[canrx_pkg::FLT_ATTACH_BIT]
                        && (flt[canrx_pkg::FLT_EXT_BIT] == req_frame_ide) && id_eq;
         full_vec[m]  = (fill_ff[m] == FILL_W'(QUEUE_DEPTH));
      end
      acc_vec  = match_vec & ~full_vec;
      drop_vec = match_vec & full_vec;
   end

   // pop lookup: mailbox, head address, updated fill
   always_comb begin
      rd_ok        = (32'(req_read_index) < NUM_MAILBOXES);
      rd_mb        = MB_W'(req_read_index);
      rd_hit       = rd_ok && (fill_ff[rd_mb] != '0);
      rd_fill_left = rd_hit ? (fill_ff[rd_mb] - FILL_W'(1)) : fill_ff[rd_mb];
      if (32'(head_ff[rd_mb]) == QUEUE_DEPTH - 1) begin
         rd_head_next = '0;
      end else begin
         rd_head_next = head_ff[rd_mb] + SLOT_W'(1);
      end
      rd_addr   = ADDR_W'(32'(rd_mb) * QUEUE_DEPTH + 32'(head_ff[rd_mb]));
      rd_filter = filter_ff[rd_mb];
   end

   // write sweep: lowest pending mailbox, slot behind its tail
   always_comb begin
      wr_sel = '0;
      wr_mb  = '0;
      for (int m = NUM_MAILBOXES - 1; m >= 0; m--) begin
         if (pend_ff[m]) begin
            wr_sel    = '0;
            wr_sel[m] = 1'b1;
            wr_mb     = MB_W'(m);
         end
      end
      wr_sum = SUM_W'(head_ff[wr_mb]) + SUM_W'(fill_ff[wr_mb]) - SUM_W'(1);
      if (wr_sum >= SUM_W'(QUEUE_DEPTH)) begin
         wr_slot = SLOT_W'(wr_sum - SUM_W'(QUEUE_DEPTH));
      end else begin
         wr_slot = SLOT_W'(wr_sum);
      end
      wr_addr = ADDR_W'(32'(wr_mb) * QUEUE_DEPTH + 32'(wr_slot));
   end

   // sequencer next state
   always_comb begin
      state_in   = state_ff;
      pend_in    = pend_ff;
      wr_en      = 1'b0;
      rdata_load = 1'b0;
      case (state_ff)
         canrx_pkg::ST_IDLE: begin
            if (take_route && (acc_vec != '0)) begin
               pend_in  = acc_vec;
               state_in = canrx_pkg::ST_WRITE;
            end else if (take_read) begin
               state_in = canrx_pkg::ST_RDATA;
            end
         end
         canrx_pkg::ST_WRITE: begin
            wr_en   = 1'b1;
            pend_in = pend_ff & ~wr_sel;
            if (pend_in == '0) begin
               state_in = canrx_pkg::ST_IDLE;
            end
         end
         canrx_pkg::ST_RDATA: begin
            rdata_load = 1'b1;
            state_in   = canrx_pkg::ST_IDLE;
         end
         default: begin
            state_in = canrx_pkg::ST_IDLE;
            pend_in  = '0;
         end
      endcase
   end

   // state register and pending mask
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= canrx_pkg::ST_IDLE;
         pend_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   // filter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < canrx_pkg::NUM_REGS; r++) begin
            filter_ff[r] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         filter_ff[csr_index] <= csr_wdata;
      end
   end

   // fifo pointers, fill levels and drop counters
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < NUM_MAILBOXES; m++) begin
            head_ff[m] <= '0;
            fill_ff[m] <= '0;
            drop_ff[m] <= '0;
         end
      end else if (take_route) begin
         for (int m = 0; m < NUM_MAILBOXES; m++) begin
            if (acc_vec[m]) begin
               fill_ff[m] <= fill_ff[m] + FILL_W'(1);
            end
            if (drop_vec[m] && (drop_ff[m] != canrx_pkg::OVF_MAX)) begin
               drop_ff[m] <= drop_ff[m] + canrx_pkg::OVF_W'(1);
            end
         end
      end else if (take_read && rd_hit) begin
         head_ff[rd_mb] <= rd_head_next;
         fill_ff[rd_mb] <= rd_fill_left;
      end
   end

   // message memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         msg_mem[wr_addr] <= {dlc_ff, data_ff};
      end
      if (take_read && rd_hit) begin
         mem_q_ff <= msg_mem[rd_addr];
      end
   end

   // frame payload capture
   always_ff @(posedge clock) begin
      if (take_route) begin
         dlc_ff  <= req_frame_dlc;
         data_ff <= req_frame_data;
      end
   end

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take_route || rdata_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (take_route) begin
         rsp_matched_ff    <= canrx_pkg::MASK_W'(acc_vec);
         rsp_dropped_ff    <= canrx_pkg::MASK_W'(drop_vec);
         rsp_read_valid_ff <= 1'b0;
         rsp_read_ide_ff   <= 1'b0;
         rsp_read_id_ff    <= '0;
         rsp_read_dlc_ff   <= '0;
         rsp_read_data_ff  <= '0;
         rsp_remaining_ff  <= '0;
         rsp_overflow_ff   <= '0;
      end else if (take_read) begin
         rsp_matched_ff    <= '0;
         rsp_dropped_ff    <= '0;
         rsp_read_valid_ff <= rd_hit;
         if (rd_ok) begin
            rsp_read_ide_ff <= rd_filter[canrx_pkg::FLT_EXT_BIT];
            if (rd_filter[canrx_pkg::FLT_EXT_BIT]) begin
               rsp_read_id_ff <= rd_filter[canrx_pkg::ID_W-1:0];
            end else begin
               rsp_read_id_ff <= canrx_pkg::ID_W'(rd_filter[canrx_pkg::STD_ID_W-1:0]);
            end
            rsp_remaining_ff <= canrx_pkg::REMAIN_W'(rd_fill_left);
            rsp_overflow_ff  <= drop_ff[rd_mb];
         end else begin
            rsp_read_ide_ff  <= 1'b0;
            rsp_read_id_ff   <= '0;
            rsp_remaining_ff <= '0;
            rsp_overflow_ff  <= '0;
         end
      end else if (rdata_load) begin
         if (rsp_read_valid_ff) begin
            rsp_read_dlc_ff  <= mem_q_ff[ENTRY_W-1:canrx_pkg::DATA_W];
            rsp_read_data_ff <= mem_q_ff[canrx_pkg::DATA_W-1:0];
         end else begin
            rsp_read_dlc_ff  <= '0;
            rsp_read_data_ff <= '0;
         end
      end
   end

   // output ports
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_matched_mask   = rsp_matched_ff;
   assign rsp_dropped_mask   = rsp_dropped_ff;
   assign rsp_read_valid     = rsp_read_valid_ff;
   assign rsp_read_ide       = rsp_read_ide_ff;
   assign rsp_read_id        = rsp_read_id_ff;
   assign rsp_read_dlc       = rsp_read_dlc_ff;
   assign rsp_read_data      = rsp_read_data_ff;
   assign rsp_remaining      = rsp_remaining_ff;
   assign rsp_overflow_count = rsp_overflow_ff;

endmodule

[src/canrx_checker.sv]
// canrx_checker: port-level assertions for can_rx_mailbox_router, bound to the top level
// depends on canrx_pkg and can_rx_mailbox_router

module canrx_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              req_mode,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [canrx_pkg::MASK_W-1:0]      rsp_matched_mask,
   input logic [canrx_pkg::MASK_W-1:0]      rsp_dropped_mask,
   input logic                              rsp_read_valid,
   input logic [canrx_pkg::DLC_W-1:0]       rsp_read_dlc,
   input logic [canrx_pkg::DATA_W-1:0]      rsp_read_data
);

   logic route_beat;
   logic read_beat;

   assign route_beat = req_valid && !req_stall && (req_mode == canrx_pkg::MODE_ROUTE);
   assign read_beat  = req_valid && !req_stall && (req_mode == canrx_pkg::MODE_READ);

   // reset leaves no response pending
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a routed frame answers in the next cycle with disjoint masks and no read data
   a_route_rsp: assert property (@(posedge clock) disable iff (reset)
      route_beat |=> (rsp_valid && ((rsp_matched_mask & rsp_dropped_mask) == '0)
                      && !rsp_read_valid))
      else $error("route response missing or malformed");

   // a pop answers with clear masks once its read data is loaded
   a_read_rsp: assert property (@(posedge clock) disable iff (reset)
      read_beat |-> ##2 (rsp_valid && (rsp_matched_mask == '0) && (rsp_dropped_mask == '0)))
      else $error("read response missing or malformed");

   // an empty or missing mailbox returns no message bytes
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_read_valid) |-> ((rsp_read_dlc == '0) && (rsp_read_data == '0)))
      else $error("message bytes on an empty read");

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_read_data)
                                    && $stable(rsp_matched_mask)))
      else $error("stalled response changed");

endmodule

bind can_rx_mailbox_router canrx_checker u_canrx_checker (.*);

[test/can_rx_mailbox_router_tb.sv]
// can_rx_mailbox_router_tb: self-checking bench for the can receive mailbox router
// depends on canrx_pkg and can_rx_mailbox_router; tracks filters, mailbox fifos and
// drop counters on its own and checks every response beat against that state

module can_rx_mailbox_router_tb;

   localparam int NUM_BOX        = canrx_pkg::NUM_MAILBOXES_DEF;
   localparam int DEPTH          = canrx_pkg::QUEUE_DEPTH_DEF;
   localparam int ID_W           = canrx_pkg::ID_W;
   localparam int DLC_W          = canrx_pkg::DLC_W;
   localparam int DATA_W         = canrx_pkg::DATA_W;
   localparam int INDEX_W        = canrx_pkg::INDEX_W;
   localparam int MASK_W         = canrx_pkg::MASK_W;
   localparam int REMAIN_W       = canrx_pkg::REMAIN_W;
   localparam int OVF_W          = canrx_pkg::OVF_W;
   localparam int CSR_INDEX_W    = canrx_pkg::CSR_INDEX_W;
   localparam int FILTER_W       = canrx_pkg::FILTER_W;
   localparam int STD_ID_W       = canrx_pkg::STD_ID_W;
   localparam int SETTLE_CYCLES  = 10;
   localparam int PAUSE_CYCLES   = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MIX_ITEMS      = 200;
   localparam int MIX_PHASES     = 6;
   localparam int BURST_EXTRA    = 20;
   localparam logic [ID_W-1:0] BURST_ID = 29'h0ABCDEF;

   typedef enum int {MBX0_FILTER, MBX1_FILTER, MBX2_FILTER, MBX3_FILTER} filter_reg_type;

   typedef struct packed {
      logic                mode;
      logic                ide;
      logic [ID_W-1:0]     id;
      logic [DLC_W-1:0]    dlc;
      logic [DATA_W-1:0]   data;
      logic [INDEX_W-1:0]  rindex;
   } can_item_type;

   typedef struct packed {
      logic [MASK_W-1:0]   matched;
      logic [MASK_W-1:0]   dropped;
      logic                rd_valid;
      logic                rd_ide;
      logic [ID_W-1:0]     rd_id;
      logic [DLC_W-1:0]    rd_dlc;
      logic [DATA_W-1:0]   rd_data;
      logic [REMAIN_W-1:0] remaining;
      logic [OVF_W-1:0]    overflow;
   } mailbox_result_type;

   // clock, reset and block ports
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_mode = canrx_pkg::MODE_ROUTE;
   logic                   req_frame_ide = 1'b0;
   logic [ID_W-1:0]        req_frame_id = '0;
   logic [DLC_W-1:0]       req_frame_dlc = '0;
   logic [DATA_W-1:0]      req_frame_data = '0;
   logic [INDEX_W-1:0]     req_read_index = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [MASK_W-1:0]      rsp_matched_mask;
   logic [MASK_W-1:0]      rsp_dropped_mask;
   logic                   rsp_read_valid;
   logic                   rsp_read_ide;
   logic [ID_W-1:0]        rsp_read_id;
   logic [DLC_W-1:0]       rsp_read_dlc;
   logic [DATA_W-1:0]      rsp_read_data;
   logic [REMAIN_W-1:0]    rsp_remaining;
   logic [OVF_W-1:0]       rsp_overflow_count;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [FILTER_W-1:0]    csr_wdata = '0;

   // mirror of the mailbox state
   logic [FILTER_W-1:0]    filter_copy [NUM_BOX];
   logic [DATA_W-1:0]      fifo_data [NUM_BOX][DEPTH];
   logic [DLC_W-1:0]       fifo_dlc [NUM_BOX][DEPTH];
   int                     fifo_head [NUM_BOX];
   int                     fifo_fill [NUM_BOX];
   logic [OVF_W-1:0]       drop_count [NUM_BOX];

   can_item_type           frame_feed [$];
   mailbox_result_type     due_replies [$];

   int  queued_items = 0;
   int  accepted_items = 0;
   int  failures = 0;
   int  routed_frames = 0;
   int  stored_copies = 0;
   int  dropped_copies = 0;
   int  mailbox_reads = 0;
   int  empty_reads = 0;
   int  pause_orders = 0;
   int  pause_seen = 0;
   int  pause_left = 0;
   int  req_wait = 0;
   int  rsp_wait = 0;
   int  quiet_cycles = 0;
   bit  calm = 1'b0;
   bit  req_taken = 1'b0;
   bit  rsp_taken = 1'b0;

   can_rx_mailbox_router #(
      .NUM_MAILBOXES(NUM_BOX),
      .QUEUE_DEPTH  (DEPTH)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_frame_ide     (req_frame_ide),
      .req_frame_id      (req_frame_id),
      .req_frame_dlc     (req_frame_dlc),
      .req_frame_data    (req_frame_data),
      .req_read_index    (req_read_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_matched_mask  (rsp_matched_mask),
      .rsp_dropped_mask  (rsp_dropped_mask),
      .rsp_read_valid    (rsp_read_valid),
      .rsp_read_ide      (rsp_read_ide),
      .rsp_read_id       (rsp_read_id),
      .rsp_read_dlc      (rsp_read_dlc),
      .rsp_read_data     (rsp_read_data),
      .rsp_remaining     (rsp_remaining),
      .rsp_overflow_count(rsp_overflow_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = ~clock;
   end

   // route a frame into every matching mailbox, or pop one mailbox
   function automatic mailbox_result_type mailbox_outcome(can_item_type it);
      mailbox_result_type r;
      logic [FILTER_W-1:0] f;
      logic hit;
      int m;
      int slot;
      r = '0;
      if (it.mode == canrx_pkg::MODE_ROUTE) begin
         for (int b = 0; b < NUM_BOX; b++) begin
            f = filter_copy[b];
            // standard ids compare on the low 11 bits only
            hit = f[canrx_pkg::FLT_ATTACH_BIT] && (f[canrx_pkg::FLT_EXT_BIT] == it.ide) &&
                  (it.ide ? (f[ID_W-1:0] == it.id)
                          : (f[STD_ID_W-1:0] == it.id[STD_ID_W-1:0]));
            if (hit) begin
               if (fifo_fill[b] >= DEPTH) begin
                  r.dropped[b] = 1'b1;
                  if (drop_count[b] != canrx_pkg::OVF_MAX) drop_count[b]++;
               end else begin
                  slot = (fifo_head[b] + fifo_fill[b]) % DEPTH;
                  fifo_data[b][slot] = it.data;
                  fifo_dlc[b][slot] = it.dlc;
                  fifo_fill[b]++;
                  r.matched[b] = 1'b1;
               end
            end
         end
      end else begin
         m = int'(it.rindex);
         f = filter_copy[m];
         r.rd_ide = f[canrx_pkg::FLT_EXT_BIT];
         r.rd_id = f[canrx_pkg::FLT_EXT_BIT] ? f[ID_W-1:0]
                                             : {{(ID_W-STD_ID_W){1'b0}}, f[STD_ID_W-1:0]};
         // empty mailbox still reports its id, fill and drop count
         if (fifo_fill[m] != 0) begin
            r.rd_valid = 1'b1;
            r.rd_dlc = fifo_dlc[m][fifo_head[m]];
            r.rd_data = fifo_data[m][fifo_head[m]];
            fifo_head[m] = (fifo_head[m] + 1) % DEPTH;
            fifo_fill[m]--;
         end
         r.remaining = REMAIN_W'(fifo_fill[m]);
         r.overflow = drop_count[m];
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                       input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endfunction

   function automatic logic [FILTER_W-1:0] filter_word(input logic attach, input logic ext,
                                                       input logic [ID_W-1:0] id);
      return {attach, ext, id};
   endfunction

   // request driver: one beat per queued item, random gap before the next unless calm
   always @(negedge clock) begin : request_driver
      can_item_type upcoming;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_wait > 0) begin
            req_wait--;
            req_valid <= 1'b0;
         end else if (frame_feed.size() > 0) begin
            upcoming = frame_feed.pop_front();
            req_mode <= upcoming.mode;
            req_frame_ide <= upcoming.ide;
            req_frame_id <= upcoming.id;
            req_frame_dlc <= upcoming.dlc;
            req_frame_data <= upcoming.data;
            req_read_index <= upcoming.rindex;
            req_valid <= 1'b1;
            req_wait = calm ? 0 : $urandom_range(0, 15);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response receiver: random stall per beat unless calm, plus an occasional long hold-off
   always @(negedge clock) begin
      if (pause_seen != pause_orders) begin
         pause_seen = pause_orders;
         pause_left = PAUSE_CYCLES;
      end
      if (rsp_taken) rsp_wait = calm ? 0 : $urandom_range(0, 15);
      if (pause_left > 0) begin
         pause_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: predict on every request beat, compare on every response beat
   always @(posedge clock) begin : beat_monitor
      can_item_type seen;
      mailbox_result_type want;
      req_taken <= !reset && req_valid && !req_stall;
      rsp_taken <= !reset && rsp_valid && !rsp_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            seen.mode = req_mode;
            seen.ide = req_frame_ide;
            seen.id = req_frame_id;
            seen.dlc = req_frame_dlc;
            seen.data = req_frame_data;
            seen.rindex = req_read_index;
            want = mailbox_outcome(seen);
            due_replies = {due_replies, want};
            accepted_items++;
            if (seen.mode == canrx_pkg::MODE_ROUTE) begin
               routed_frames++;
            end else begin
               mailbox_reads++;
               if (!want.rd_valid) empty_reads++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_replies.size() == 0) begin
               $error("response beat with no request waiting");
               failures++;
            end else begin
               want = due_replies.pop_front();
               stored_copies += $countones(want.matched);
               dropped_copies += $countones(want.dropped);
               check_field("matched_mask", DATA_W'(want.matched), DATA_W'(rsp_matched_mask));
               check_field("dropped_mask", DATA_W'(want.dropped), DATA_W'(rsp_dropped_mask));
               check_field("read_valid", DATA_W'(want.rd_valid), DATA_W'(rsp_read_valid));
               check_field("read_ide", DATA_W'(want.rd_ide), DATA_W'(rsp_read_ide));
               check_field("read_id", DATA_W'(want.rd_id), DATA_W'(rsp_read_id));
               check_field("read_dlc", DATA_W'(want.rd_dlc), DATA_W'(rsp_read_dlc));
               check_field("read_data", want.rd_data, rsp_read_data);
               check_field("remaining", DATA_W'(want.remaining), DATA_W'(rsp_remaining));
               check_field("overflow_count", DATA_W'(want.overflow),
                           DATA_W'(rsp_overflow_count));
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $error("no handshake for %0d cycles, %0d responses outstanding",
                WATCHDOG_LIMIT, due_replies.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic queue_item(input can_item_type it);
      frame_feed = {frame_feed, it};
      queued_items++;
   endtask

   task automatic route_frame(input logic ide, input logic [ID_W-1:0] id,
                              input logic [DLC_W-1:0] dlc, input logic [DATA_W-1:0] data);
      can_item_type it;
      it.mode = canrx_pkg::MODE_ROUTE;
      it.ide = ide;
      it.id = id;
      it.dlc = dlc;
      it.data = data;
      it.rindex = INDEX_W'($urandom);
      queue_item(it);
   endtask

   // read beats carry random frame fields, which the block ignores
   task automatic read_box(input int idx);
      can_item_type it;
      it.mode = canrx_pkg::MODE_READ;
      it.ide = 1'($urandom);
      it.id = ID_W'($urandom);
      it.dlc = DLC_W'($urandom);
      it.data = {$urandom, $urandom};
      it.rindex = INDEX_W'(idx);
      queue_item(it);
   endtask

   task automatic write_filter(input int idx, input logic [FILTER_W-1:0] value);
      @(negedge clock);
      csr_index <= idx[CSR_INDEX_W-1:0];
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      filter_copy[idx] = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // frames mostly aimed at a programmed filter, some noise frames, some reads
   task automatic feed_mix(input int count, input int read_pct);
      can_item_type it;
      int m;
      repeat (count) begin
         it.mode = canrx_pkg::MODE_ROUTE;
         it.ide = 1'($urandom);
         it.id = ID_W'($urandom);
         it.dlc = DLC_W'($urandom);
         it.data = {$urandom, $urandom};
         it.rindex = INDEX_W'($urandom);
         if ($urandom_range(1, 100) <= read_pct) begin
            it.mode = canrx_pkg::MODE_READ;
         end else if ($urandom_range(1, 10) <= 7) begin
            m = $urandom_range(0, NUM_BOX - 1);
            it.ide = filter_copy[m][canrx_pkg::FLT_EXT_BIT];
            if (it.ide) it.id = filter_copy[m][ID_W-1:0];
            else it.id[STD_ID_W-1:0] = filter_copy[m][STD_ID_W-1:0];
         end
         queue_item(it);
      end
   endtask

   // wait for every response, then for the block to finish its memory writes
   task automatic settle();
      while (accepted_items != queued_items || due_replies.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : sequencer
      logic [FILTER_W-1:0] fw;
      logic [ID_W-1:0] junk_id;
      for (int m = 0; m < NUM_BOX; m++) begin
         filter_copy[m] = '0;
         fifo_head[m] = 0;
         fifo_fill[m] = 0;
         drop_count[m] = '0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: id extremes, low-bit standard compare, detached mailbox
      write_filter(MBX0_FILTER, filter_word(1'b1, 1'b0, 29'h7FF));
      write_filter(MBX1_FILTER, filter_word(1'b1, 1'b1, 29'h1FFFFFFF));
      write_filter(MBX2_FILTER, filter_word(1'b0, 1'b1, 29'h0));
      write_filter(MBX3_FILTER, filter_word(1'b1, 1'b0, 29'h1FFFF923));
      route_frame(1'b0, 29'h7FF, 4'hF, '1);
      route_frame(1'b0, 29'h1FFFFFFF, 4'h0, '0);
      route_frame(1'b1, 29'h1FFFFFFF, 4'h8, 64'h0123_4567_89AB_CDEF);
      route_frame(1'b1, 29'h7FF, 4'h3, 64'hDEAD_BEEF_0000_FFFF);
      route_frame(1'b0, 29'h123, 4'h1, 64'h8000_0000_0000_0001);
      route_frame(1'b1, 29'h0, 4'h2, 64'h5555_AAAA_5555_AAAA);
      read_box(2);
      read_box(0);
      read_box(0);
      read_box(0);
      read_box(1);
      read_box(3);
      // fill mailbox 3 past its depth
      repeat (DEPTH + 2) begin
         junk_id = ID_W'($urandom);
         junk_id[STD_ID_W-1:0] = 11'h123;
         route_frame(1'b0, junk_id, DLC_W'($urandom), {$urandom, $urandom});
      end
      read_box(3);
      settle();

      // one frame stored in one mailbox and dropped by another
      write_filter(MBX2_FILTER, filter_word(1'b1, 1'b0, 29'h123));
      route_frame(1'b0, 29'h123, 4'h7, {$urandom, $urandom});
      route_frame(1'b0, 29'h123, 4'h9, {$urandom, $urandom});
      read_box(2);
      settle();

      // random phases over detached, all-ones and random filter settings
      for (int p = 0; p < MIX_PHASES; p++) begin
         calm = (p % 2 == 0);
         for (int m = 0; m < NUM_BOX; m++) begin
            if (p == 0) begin
               fw = '0;
            end else if (p == 1) begin
               fw = '1;
            end else begin
               fw = FILTER_W'($urandom);
               fw[canrx_pkg::FLT_ATTACH_BIT] = ($urandom_range(0, 7) != 0);
               if (m > 0 && $urandom_range(0, 3) == 0) fw = filter_copy[$urandom_range(0, m - 1)];
            end
            write_filter(m, fw);
         end
         feed_mix(MIX_ITEMS, $urandom_range(25, 60));
         if (p == 3) pause_orders++;
         settle();
      end

      // back-to-back burst that overflows mailbox 0 and grows its drop count
      calm = 1'b1;
      write_filter(MBX0_FILTER, filter_word(1'b1, 1'b1, BURST_ID));
      repeat (DEPTH + BURST_EXTRA) begin
         route_frame(1'b1, BURST_ID, DLC_W'($urandom), {$urandom, $urandom});
      end
      read_box(0);
      read_box(0);
      settle();

      $display("routed %0d frames: %0d copies stored, %0d dropped", routed_frames,
               stored_copies, dropped_copies);
      $display("popped mailboxes %0d times, %0d of them empty, over %0d filter settings",
               mailbox_reads, empty_reads, MIX_PHASES + 3);
      if (failures == 0 && due_replies.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
